// ===== hdl/dvru_pkg.sv =====
// shared types and constants for the distance-vector route update block
package dvru_pkg;
   localparam int MAX_NODES_DEF = 16;
   localparam logic signed [15:0] COST_LIMIT = 16'sd1000;
   localparam logic signed [15:0] UNREACHABLE = -16'sd1;
   localparam logic [16:0] DIST_SAT = 17'd32767;

   typedef enum logic [1:0] {
      OP_COST  = 2'd0,
      OP_ELEM  = 2'd1,
      OP_QUERY = 2'd2,
      OP_EMIT  = 2'd3
   } op_type;

   localparam logic [0:0] CSR_SELF  = 1'b0;
   localparam logic [0:0] CSR_COUNT = 1'b1;

   typedef struct packed {
      logic [1:0]         operation;
      logic [3:0]         neighbor;
      logic [3:0]         dest;
      logic signed [15:0] value;
      logic               last_element;
   } req_type;

   typedef struct packed {
      logic [3:0]         route_dest;
      logic signed [15:0] distance;
      logic [3:0]         next_hop;
      logic               changed;
      logic               last_result;
   } rsp_type;

   // classified command passed from front to back
   typedef struct packed {
      logic               recompute;
      logic               emit_if_changed;
      logic               query;
      logic               emit;
      logic               query_oob;
      logic [3:0]         dest;
   } cmd_type;
endpackage

// ===== hdl/dvru_front.sv =====
// front end: stores table writes and queues classified commands
module dvru_front import dvru_pkg::*; #(
   parameter int MAX_NODES = MAX_NODES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  logic [4:0] n_eff,
   output logic    cost_we,
   output logic [3:0] cost_idx,
   output logic signed [15:0] cost_val,
   output logic    vec_we,
   output logic [3:0] vec_nb,
   output logic [3:0] vec_dest,
   output logic signed [15:0] vec_val,
   output logic    cmd_valid,
   output cmd_type cmd_data,
   input  logic    cmd_take
);
   localparam int QD = 2;
   cmd_type q_ff [QD];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       acc, in_range_d, in_range_nb, push;
   cmd_type    c;

   // tables must not change while the back end recomputes or reads
   assign req_stall = (cnt_ff != 2'd0);
   assign acc = req_valid && !req_stall;
   assign in_range_d  = ({28'd0, req_data.dest} < 32'(MAX_NODES));
   assign in_range_nb = ({28'd0, req_data.neighbor} < 32'(MAX_NODES));

   always_comb begin
      c = '0;
      c.dest = req_data.dest;
      cost_we = 1'b0;
      vec_we = 1'b0;
      cost_idx = req_data.dest;
      cost_val = (req_data.value > COST_LIMIT) ? UNREACHABLE : req_data.value;
      vec_nb = req_data.neighbor;
      vec_dest = req_data.dest;
      vec_val = req_data.value;
      case (op_type'(req_data.operation))
         OP_COST: begin
            cost_we = acc && in_range_d;
            c.recompute = in_range_d;
         end
         OP_ELEM: begin
            vec_we = acc && in_range_d && in_range_nb;
            c.recompute = in_range_d && in_range_nb && req_data.last_element;
            c.emit_if_changed = c.recompute;
         end
         OP_QUERY: begin
            c.query = 1'b1;
            c.query_oob = ({1'b0, req_data.dest} >= n_eff);
         end
         default: c.emit = 1'b1;
      endcase
   end

   assign push = acc && (c.recompute || c.query || c.emit);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data = q_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, cmd_take};
      rd_in = rd_ff ^ cmd_take;
      wr_in = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
      end
      if (push) q_ff[wr_ff] <= c;
   end
endmodule

// ===== hdl/dvru_back.sv =====
// back end: tables, bellman-ford sweep and result generation
module dvru_back import dvru_pkg::*; #(
   parameter int MAX_NODES = MAX_NODES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic [3:0] self_idx,
   input  logic [4:0] n_eff,
   input  logic    cost_we,
   input  logic [3:0] cost_idx,
   input  logic signed [15:0] cost_val,
   input  logic    vec_we,
   input  logic [3:0] vec_nb,
   input  logic [3:0] vec_dest,
   input  logic signed [15:0] vec_val,
   input  logic    cmd_valid,
   input  cmd_type cmd_data,
   output logic    cmd_take,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   localparam int TN = (MAX_NODES < 16) ? MAX_NODES : 16;
   localparam int VD = TN * TN;
   localparam int VA = $clog2(VD);

   typedef enum logic [2:0] {
      S_IDLE, S_INIT, S_READ, S_ACC, S_WRITE, S_OUT, S_DONE
   } state_type;

   logic signed [15:0] cost_ff [TN];
   logic signed [15:0] dist_ff [TN];
   logic [3:0]         hop_ff  [TN];
   logic signed [15:0] vec_mem [VD];
   logic [VD-1:0]      vwr_ff;
   logic signed [15:0] vrd_ff;
   logic               vrd_v_ff;

   state_type st_ff;
   cmd_type   cmd_ff;
   logic [3:0] i_ff, j_ff;
   logic signed [15:0] d_ff;
   logic [3:0] h_ff;
   logic chg_ff, chg_acc_ff;
   logic out_v_ff;
   rsp_type out_ff;

   logic [VA-1:0] waddr, raddr;
   logic signed [15:0] e_val, cj;
   logic [16:0] s_wide;
   logic signed [15:0] s_sat;
   logic use_j, take_sum, last_i, last_j, out_free;

   assign waddr = VA'(32'(vec_nb) * 32'(TN) + 32'(vec_dest));
   assign raddr = VA'(32'(j_ff) * 32'(TN) + 32'(i_ff));

   always_ff @(posedge clock) begin
      if (vec_we) vec_mem[waddr] <= vec_val;
      vrd_ff <= vec_mem[raddr];
      vrd_v_ff <= vwr_ff[raddr];
   end

   assign e_val = vrd_v_ff ? vrd_ff : ((j_ff == i_ff) ? 16'sd0 : UNREACHABLE);
   assign cj = cost_ff[j_ff[$clog2(TN)-1:0]];
   assign s_wide = {1'b0, e_val} + {1'b0, cj};
   assign s_sat = (s_wide > DIST_SAT) ? 16'sd32767 : s_wide[15:0];
   assign use_j = (j_ff != self_idx) && !cj[15] && !e_val[15];
   assign take_sum = use_j && (d_ff <= 16'sd0 || s_sat < d_ff);
   assign last_i = ({1'b0, i_ff} + 5'd1 >= n_eff);
   assign last_j = ({1'b0, j_ff} + 5'd1 >= n_eff);
   assign out_free = !out_v_ff || !rsp_stall;
   assign cmd_take = (st_ff == S_DONE);
   assign rsp_valid = out_v_ff;
   assign rsp_data = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         out_v_ff <= 1'b0;
         chg_ff <= 1'b0;
         vwr_ff <= '0;
         for (int k = 0; k < TN; k++) begin
            cost_ff[k] <= (k == 0) ? 16'sd0 : UNREACHABLE;
            dist_ff[k] <= 16'sd0;
            hop_ff[k] <= 4'd0;
         end
      end else begin
         if (cost_we) cost_ff[cost_idx[$clog2(TN)-1:0]] <= cost_val;
         if (vec_we) vwr_ff[waddr] <= 1'b1;
         if (out_v_ff && !rsp_stall && st_ff != S_OUT) out_v_ff <= 1'b0;
         case (st_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff <= cmd_data;
                  i_ff <= cmd_data.query ? cmd_data.dest : 4'd0;
                  if (cmd_data.recompute) begin
                     chg_acc_ff <= 1'b0;
                     st_ff <= S_INIT;
                  end else begin
                     st_ff <= S_OUT;
                  end
               end
            end
            S_INIT: begin
               if (i_ff == self_idx) begin
                  hop_ff[i_ff[$clog2(TN)-1:0]] <= i_ff;
                  if (last_i) st_ff <= S_WRITE;
                  else i_ff <= i_ff + 4'd1;
               end else begin
                  d_ff <= cost_ff[i_ff[$clog2(TN)-1:0]];
                  h_ff <= cost_ff[i_ff[$clog2(TN)-1:0]][15] ? 4'd0 : i_ff;
                  j_ff <= 4'd0;
                  st_ff <= S_READ;
               end
            end
            S_READ: st_ff <= S_ACC;
            S_ACC: begin
               logic signed [15:0] nd;
               logic [3:0] nh;
               nd = take_sum ? s_sat : d_ff;
               nh = take_sum ? j_ff : h_ff;
               d_ff <= nd;
               h_ff <= nh;
               if (last_j) begin
                  if (!(dist_ff[i_ff[$clog2(TN)-1:0]][15] && nd[15]) &&
                      dist_ff[i_ff[$clog2(TN)-1:0]] != nd)
                     chg_acc_ff <= 1'b1;
                  dist_ff[i_ff[$clog2(TN)-1:0]] <= nd;
                  hop_ff[i_ff[$clog2(TN)-1:0]] <= nh;
                  if (last_i) st_ff <= S_WRITE;
                  else begin
                     i_ff <= i_ff + 4'd1;
                     st_ff <= S_INIT;
                  end
               end else begin
                  j_ff <= j_ff + 4'd1;
                  st_ff <= S_READ;
               end
            end
            S_WRITE: begin
               chg_ff <= chg_acc_ff;
               i_ff <= 4'd0;
               if (cmd_ff.emit_if_changed && chg_acc_ff) st_ff <= S_OUT;
               else st_ff <= S_DONE;
            end
            S_OUT: begin
               if (out_free) begin
                  out_v_ff <= 1'b1;
                  out_ff.route_dest <= i_ff;
                  out_ff.changed <= chg_ff;
                  if (cmd_ff.query) begin
                     out_ff.distance <= cmd_ff.query_oob ? UNREACHABLE
                                        : dist_ff[i_ff[$clog2(TN)-1:0]];
                     out_ff.next_hop <= cmd_ff.query_oob ? 4'd0
                                        : hop_ff[i_ff[$clog2(TN)-1:0]];
                     out_ff.last_result <= 1'b1;
                     st_ff <= S_DONE;
                  end else begin
                     out_ff.distance <= dist_ff[i_ff[$clog2(TN)-1:0]];
                     out_ff.next_hop <= hop_ff[i_ff[$clog2(TN)-1:0]];
                     out_ff.last_result <= last_i;
                     if (last_i) st_ff <= S_DONE;
                     else i_ff <= i_ff + 4'd1;
                  end
               end
            end
            S_DONE: st_ff <= S_IDLE;
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== hdl/distance_vector_route_update.sv =====
// Distance-vector route update engine for one node.
// Items arrive on req_ (valid/stall) as link cost updates, neighbour vector
// elements, route queries and emit requests. Results leave on rsp_ as
// route entries; last_result marks the final one of an item.
// Configuration: csr_we, csr_index (0 self index, 1 node count), csr_wdata.
// Table writes are stored on acceptance; recomputing items, queries and
// emits go to a two-entry command queue and the back end walks them.
// A recomputation visits each destination against every neighbour, one
// neighbour at a time (vector memory read, then add and compare), and a
// recomputing item holds the input until its sweep and results are done.
// A query result passes the command queue, the S_OUT state and the output
// register; an emit gives one result per cycle while rsp_stall is low.
// req_stall is high while a command is pending, so one item is worked on
// at a time. rsp_stall holds the output register and result generation waits.
// Reset restores the tables to their reset values at once; the vector
// memory is covered by per-entry written flags.
module distance_vector_route_update import dvru_pkg::*; #(
   parameter int MAX_NODES = MAX_NODES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   input  logic    csr_we,
   input  logic    csr_index,
   input  logic [4:0] csr_wdata
);
   localparam int TN = (MAX_NODES < 16) ? MAX_NODES : 16;

   logic [3:0] self_ff;
   logic [4:0] count_ff, n_eff;
   logic cost_we, vec_we, cmd_valid, cmd_take;
   logic [3:0] cost_idx, vec_nb, vec_dest;
   logic signed [15:0] cost_val, vec_val;
   cmd_type cmd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         self_ff <= 4'd0;
         count_ff <= 5'd16;
      end else if (csr_we) begin
         if (csr_index == CSR_SELF) self_ff <= csr_wdata[3:0];
         else count_ff <= csr_wdata;
      end
   end

   always_comb begin
      n_eff = count_ff;
      if ({27'd0, n_eff} > 32'(TN)) n_eff = 5'(TN);
      if (n_eff == 5'd0) n_eff = 5'd1;
   end

   dvru_front #(.MAX_NODES(MAX_NODES)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data, .n_eff,
      .cost_we, .cost_idx, .cost_val, .vec_we, .vec_nb, .vec_dest, .vec_val,
      .cmd_valid, .cmd_data, .cmd_take
   );

   dvru_back #(.MAX_NODES(MAX_NODES)) u_back (
      .clock, .reset, .self_idx(self_ff), .n_eff,
      .cost_we, .cost_idx, .cost_val, .vec_we, .vec_nb, .vec_dest, .vec_val,
      .cmd_valid, .cmd_data, .cmd_take, .rsp_valid, .rsp_stall, .rsp_data
   );

`ifndef NO_ASSERTIONS
   a_take_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> cmd_valid) else $error("command taken from empty queue");
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      cmd_valid |-> !cost_we && !vec_we) else $error("table write during command");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");
`endif
endmodule

// ===== test/tb_distance_vector_route_update.sv =====
// testbench for the distance-vector route update block: directed and random items against a predictor
`timescale 1ns / 100ps

module tb_distance_vector_route_update;
   import dvru_pkg::*;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_data;
   logic       csr_we;
   logic       csr_index;
   logic [4:0] csr_wdata;

   distance_vector_route_update uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // routing state as the block should hold it
   logic signed [15:0] link_cost [16];
   logic signed [15:0] heard_vec [16][16];
   logic signed [15:0] own_dist [16];
   logic [3:0]         hop_tab [16];
   logic [3:0]         self_idx;
   logic [4:0]         node_cnt;
   logic               chg;

   rsp_type expected_routes [$];
   int      failures;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("tb_distance_vector_route_update NOT OK");
      $finish;
   end

   function automatic int nodes_active();
      int n;
      n = node_cnt;
      if (n > 16) n = 16;
      if (n < 1) n = 1;
      return n;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic predict_reset();
      for (int i = 0; i < 16; i++) begin
         link_cost[i] = (i == 0) ? 16'sd0 : UNREACHABLE;
         own_dist[i] = 16'sd0;
         hop_tab[i] = 4'd0;
         for (int j = 0; j < 16; j++) heard_vec[i][j] = (i == j) ? 16'sd0 : UNREACHABLE;
      end
      self_idx = 4'd0;
      node_cnt = 5'd16;
      chg = 1'b0;
   endtask

   task automatic bellman_ford();
      int n, d, s;
      logic signed [15:0] prev [16];
      logic [3:0] h;
      n = nodes_active();
      chg = 1'b0;
      prev = own_dist;
      for (int i = 0; i < n; i++) begin
         if (i == self_idx) begin
            hop_tab[i] = i[3:0];
         end else begin
            d = link_cost[i];
            h = (d >= 0) ? i[3:0] : 4'd0;
            for (int j = 0; j < n; j++) begin
               if (j == self_idx || link_cost[j] < 0 || heard_vec[j][i] < 0) continue;
               s = heard_vec[j][i] + link_cost[j];
               if (s > 32767) s = 32767;
               if (d <= 0 || s < d) begin
                  d = s;
                  h = j[3:0];
               end
            end
            own_dist[i] = d[15:0];
            hop_tab[i] = h;
         end
      end
      for (int i = 0; i < 16; i++)
         if (!(prev[i] < 0 && own_dist[i] < 0) && prev[i] != own_dist[i]) chg = 1'b1;
   endtask

   task automatic push_vector();
      int n;
      rsp_type r;
      n = nodes_active();
      for (int i = 0; i < n; i++) begin
         r.route_dest = i[3:0];
         r.distance = own_dist[i];
         r.next_hop = hop_tab[i];
         r.changed = chg;
         r.last_result = (i == n - 1);
         expected_routes.push_back(r);
      end
   endtask

   task automatic predict_item(input req_type it);
      rsp_type r;
      logic signed [15:0] v;
      case (op_type'(it.operation))
         OP_COST: begin
            v = (it.value > COST_LIMIT) ? UNREACHABLE : it.value;
            link_cost[it.dest] = v;
            bellman_ford();
         end
         OP_ELEM: begin
            heard_vec[it.neighbor][it.dest] = it.value;
            if (it.last_element) begin
               bellman_ford();
               if (chg) push_vector();
            end
         end
         OP_QUERY: begin
            r.route_dest = it.dest;
            r.changed = chg;
            r.last_result = 1'b1;
            if (it.dest >= nodes_active()) begin
               r.distance = UNREACHABLE;
               r.next_hop = 4'd0;
            end else begin
               r.distance = own_dist[it.dest];
               r.next_hop = hop_tab[it.dest];
            end
            expected_routes.push_back(r);
         end
         default: push_vector();
      endcase
   endtask

   task automatic send_item(input op_type op, input int nb, input int dst,
                            input int val, input bit last);
      req_type it;
      int g;
      it.operation = op;
      it.neighbor = nb[3:0];
      it.dest = dst[3:0];
      it.value = val[15:0];
      it.last_element = last;
      g = gap_len();
      if (g != 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_item(it);
      @(negedge clock);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (expected_routes.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      repeat (700) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input int val);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[4:0];
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_SELF) self_idx = val[3:0];
      else node_cnt = val[4:0];
   endtask

   function automatic int rand_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return -1;
      if (r == 1) return $urandom_range(0, 65535);
      if (r == 2) return $urandom_range(1001, 32767);
      if (r < 5) return $urandom_range(0, 5);
      return $urandom_range(0, 1000);
   endfunction

   task automatic test_directed();
      send_item(OP_EMIT, 0, 0, 0, 0);
      send_item(OP_COST, 0, 1, 4, 0);
      send_item(OP_COST, 0, 2, 1000, 0);
      send_item(OP_COST, 0, 3, 1001, 0);
      send_item(OP_COST, 0, 4, 0, 0);
      send_item(OP_COST, 0, 0, 7, 0);
      send_item(OP_ELEM, 1, 5, 32767, 0);
      send_item(OP_ELEM, 1, 6, -5, 0);
      send_item(OP_ELEM, 1, 7, 3, 1);
      send_item(OP_ELEM, 2, 5, 10, 1);
      send_item(OP_ELEM, 0, 8, 2, 1);
      send_item(OP_QUERY, 0, 5, 0, 0);
      send_item(OP_QUERY, 15, 15, -1, 1);
      send_item(OP_QUERY, 0, 0, 0, 0);
      send_item(OP_ELEM, 15, 15, 16'h8000, 1);
      send_item(OP_COST, 0, 15, 16'h7fff, 0);
      send_item(OP_EMIT, 15, 15, -1, 1);
   endtask

   task automatic test_config_sweep();
      write_csr(CSR_COUNT, 4);
      send_item(OP_QUERY, 0, 9, 0, 0);
      send_item(OP_EMIT, 0, 0, 0, 0);
      write_csr(CSR_SELF, 15);
      send_item(OP_COST, 0, 0, 2, 0);
      send_item(OP_ELEM, 1, 3, 1, 1);
      send_item(OP_EMIT, 0, 0, 0, 0);
      write_csr(CSR_COUNT, 1);
      send_item(OP_EMIT, 0, 0, 0, 0);
      write_csr(CSR_COUNT, 0);
      send_item(OP_QUERY, 0, 1, 0, 0);
      write_csr(CSR_COUNT, 31);
      write_csr(CSR_SELF, 2);
      send_item(OP_EMIT, 0, 0, 0, 0);
   endtask

   task automatic test_random_traffic();
      int n, nb, len;
      for (int phase = 0; phase < 4; phase++) begin
         write_csr(CSR_COUNT, (phase == 3) ? 16 : $urandom_range(2, 8));
         write_csr(CSR_SELF, $urandom_range(0, 15));
         n = nodes_active();
         for (int k = 0; k < 95; ) begin
            case ($urandom_range(0, 9))
               0, 1: begin
                  send_item(OP_COST, $urandom_range(0, 15), $urandom_range(0, n - 1),
                            rand_value(), $urandom_range(0, 1));
                  k++;
               end
               2, 3, 4, 5: begin
                  nb = $urandom_range(0, n - 1);
                  len = $urandom_range(1, n);
                  for (int e = 0; e < len; e++)
                     send_item(OP_ELEM, nb, (e == 0) ? $urandom_range(0, 15) : e,
                               rand_value(), e == len - 1);
                  k += len;
               end
               6, 7: begin
                  send_item(OP_QUERY, $urandom_range(0, 15), $urandom_range(0, 15),
                            rand_value(), $urandom_range(0, 1));
                  k++;
               end
               default: begin
                  send_item(OP_EMIT, $urandom_range(0, 15), $urandom_range(0, 15),
                            rand_value(), $urandom_range(0, 1));
                  k++;
               end
            endcase
         end
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall <= ($urandom_range(0, 19) == 0) ? 1'b1 : ~rsp_stall;
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_routes.size() == 0) begin
            $display("%0t unexpected route item %p", $time, rsp_data);
            failures++;
         end else begin
            e = expected_routes.pop_front();
            if (rsp_data !== e) begin
               $display("%0t route mismatch expected %p actual %p", $time, e, rsp_data);
               failures++;
            end
         end
      end
   end

   initial begin
      failures = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = 1'b0;
      csr_wdata = '0;
      predict_reset();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_config_sweep();
      test_random_traffic();
      drain();
      if (failures == 0 && expected_routes.size() == 0) begin
         $display("tb_distance_vector_route_update OK");
      end else begin
         $display("tb_distance_vector_route_update NOT OK");
      end
      $finish;
   end
endmodule
